FILE: hdl/ata_pkg.sv
// Package for the accelerometer tilt angle block: widths, CORDIC angle table, flag struct.
// No dependencies; imported by accel_tilt_angle_top.
package ata_pkg;

	localparam int unsigned ANGLE_FRAC_BITS_DEF = 6;

	localparam int unsigned WORD_W    = 16;
	localparam int unsigned CNT_W     = 10;
	localparam int unsigned SQ_W      = 19;
	localparam int unsigned R2_W      = 20;
	localparam int unsigned RT_W      = 30;
	localparam int unsigned SR_W      = 34;
	localparam int unsigned CDC_W     = 34;
	localparam int unsigned ACC_W     = 29;
	localparam int unsigned ACC_FRAC  = 20;
	localparam int unsigned SQ_STEPS  = 30;
	localparam int unsigned CDC_STEPS = 24;
	localparam int unsigned TILT_W    = 14;
	localparam int          TILT_MAX  = 8191;

	localparam logic signed [ACC_W-1:0] ACC_TOP = 29'sd94371840;

	// atan(2^-i) in degrees, Q.20
	localparam logic signed [ACC_W-1:0] ATAN_TAB [0:CDC_STEPS-1] = '{
		29'sd47185920, 29'sd27855475, 29'sd14718068, 29'sd7471121,
		29'sd3750058,  29'sd1876857,  29'sd938658,   29'sd469357,
		29'sd234682,   29'sd117342,   29'sd58671,    29'sd29335,
		29'sd14668,    29'sd7334,     29'sd3667,     29'sd1833,
		29'sd917,      29'sd458,      29'sd229,      29'sd115,
		29'sd57,       29'sd29,       29'sd14,       29'sd7
	};

	typedef struct packed {
		logic rzero;
		logic azero;
		logic zneg;
	} ata_flag_t;

endpackage

FILE: hdl/accel_tilt_angle_top.sv
// Accelerometer tilt angle: atan(sqrt(x^2+y^2)/|z|) in degrees, signed by z.
// Depends on ata_pkg (widths, atan table, flag struct).
//
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  in      | in_valid, in_ready, accel_x/y/z_word           | in
//  out     | out_valid, out_ready, tilt_angle, angle_invalid | out
//
// One item per cycle while the output is not stalled; stages: square, sum, 30 square-root bit
// stages, 24 CORDIC vectoring stages, clamp/round, sign/saturate.
// All stages advance together; while a result waits on out_ready the whole
// pipeline holds and in_ready is low.
// Reset clears the stage valid bits only.
module accel_tilt_angle_top #(
	parameter int unsigned ANGLE_FRAC_BITS = ata_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [ata_pkg::WORD_W-1:0]   accel_x_word,
	input  logic signed [ata_pkg::WORD_W-1:0]   accel_y_word,
	input  logic signed [ata_pkg::WORD_W-1:0]   accel_z_word,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [ata_pkg::TILT_W-1:0]   tilt_angle,
	output logic                                angle_invalid
);
	import ata_pkg::*;

	localparam int unsigned RND_SH = ACC_FRAC - ANGLE_FRAC_BITS;
	localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (RND_SH - 1);
	localparam logic [ACC_W-1:0] RIGHT_ANG = ACC_W'(90) << ANGLE_FRAC_BITS;
	localparam logic signed [ACC_W:0] SAT_HI = (ACC_W+1)'(TILT_MAX);
	localparam logic signed [ACC_W:0] SAT_LO = -SAT_HI - (ACC_W+1)'(1);
	localparam int ANG_LIM = ((90 << ANGLE_FRAC_BITS) > TILT_MAX) ? TILT_MAX
		: (90 << ANGLE_FRAC_BITS);
	localparam int ANG_LO = ((90 << ANGLE_FRAC_BITS) > TILT_MAX) ? -TILT_MAX - 1
		: -(90 << ANGLE_FRAC_BITS);

	logic en;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: counts, magnitudes, squares
	logic signed [CNT_W-1:0] x_cnt, y_cnt, z_cnt;
	logic [CNT_W-1:0]        x_abs, y_abs, z_abs;
	logic [2*CNT_W-1:0]      x_sq, y_sq;

	assign x_cnt = accel_x_word[WORD_W-1 -: CNT_W];
	assign y_cnt = accel_y_word[WORD_W-1 -: CNT_W];
	assign z_cnt = accel_z_word[WORD_W-1 -: CNT_W];
	assign x_abs = x_cnt[CNT_W-1] ? $unsigned(-x_cnt) : $unsigned(x_cnt);
	assign y_abs = y_cnt[CNT_W-1] ? $unsigned(-y_cnt) : $unsigned(y_cnt);
	assign z_abs = z_cnt[CNT_W-1] ? $unsigned(-z_cnt) : $unsigned(z_cnt);
	assign x_sq  = x_abs * x_abs;
	assign y_sq  = y_abs * y_abs;

	logic             vld_s1;
	logic [SQ_W-1:0]  xsq_s1, ysq_s1;
	logic [CNT_W-1:0] az_s1;
	logic             zneg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xsq_s1  <= x_sq[SQ_W-1:0];
			ysq_s1  <= y_sq[SQ_W-1:0];
			az_s1   <= z_abs;
			zneg_s1 <= z_cnt[CNT_W-1];
		end
	end

	// square root of r2 * 2^40, one root bit per stage; entry 0 is the sum stage
	logic              sq_vld_s  [0:SQ_STEPS];
	logic [SR_W-1:0]   sq_rem_s  [0:SQ_STEPS];
	logic [RT_W-1:0]   sq_root_s [0:SQ_STEPS];
	logic [R2_W-1:0]   sq_r2_s   [0:SQ_STEPS];
	logic [CNT_W-1:0]  sq_az_s   [0:SQ_STEPS];
	ata_flag_t         sq_flg_s  [0:SQ_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s[0] <= 1'b0;
		end else if (en) begin
			sq_vld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rem_s[0]       <= '0;
			sq_root_s[0]      <= '0;
			sq_r2_s[0]        <= {1'b0, xsq_s1} + {1'b0, ysq_s1};
			sq_az_s[0]        <= az_s1;
			sq_flg_s[0].rzero <= (xsq_s1 == '0) && (ysq_s1 == '0);
			sq_flg_s[0].azero <= (az_s1 == '0);
			sq_flg_s[0].zneg  <= zneg_s1;
		end
	end

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
		localparam int unsigned P = SQ_STEPS - 1 - j;
		logic [1:0]      pair;
		logic [SR_W-1:0] rsh;
		logic [SR_W-1:0] trial;

		if (P >= ACC_FRAC) begin : g_pair
			assign pair = sq_r2_s[j][2*(P-ACC_FRAC) +: 2];
		end else begin : g_zero
			assign pair = 2'b00;
		end

		assign rsh   = {sq_rem_s[j][SR_W-3:0], pair};
		assign trial = SR_W'({sq_root_s[j], 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[j+1] <= 1'b0;
			end else if (en) begin
				sq_vld_s[j+1] <= sq_vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rsh >= trial) begin
					sq_rem_s[j+1]  <= rsh - trial;
					sq_root_s[j+1] <= {sq_root_s[j][RT_W-2:0], 1'b1};
				end else begin
					sq_rem_s[j+1]  <= rsh;
					sq_root_s[j+1] <= {sq_root_s[j][RT_W-2:0], 1'b0};
				end
				sq_r2_s[j+1]  <= sq_r2_s[j];
				sq_az_s[j+1]  <= sq_az_s[j];
				sq_flg_s[j+1] <= sq_flg_s[j];
			end
		end
	end

	// CORDIC vectoring on (|z| * 2^20, root); entry 0 is the start vector
	logic                    cd_vld_s [0:CDC_STEPS];
	logic signed [CDC_W-1:0] cd_cx_s  [0:CDC_STEPS];
	logic signed [CDC_W-1:0] cd_cy_s  [0:CDC_STEPS];
	logic signed [ACC_W-1:0] cd_acc_s [0:CDC_STEPS];
	ata_flag_t               cd_flg_s [0:CDC_STEPS];

	assign cd_vld_s[0] = sq_vld_s[SQ_STEPS];
	assign cd_cx_s[0]  = CDC_W'({sq_az_s[SQ_STEPS], {ACC_FRAC{1'b0}}});
	assign cd_cy_s[0]  = CDC_W'(sq_root_s[SQ_STEPS]);
	assign cd_acc_s[0] = '0;
	assign cd_flg_s[0] = sq_flg_s[SQ_STEPS];

	for (genvar i = 0; i < CDC_STEPS; i++) begin : g_cordic
		logic signed [CDC_W-1:0] dx;
		logic signed [CDC_W-1:0] dy;

		assign dx = cd_cy_s[i] >>> i;
		assign dy = cd_cx_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cd_vld_s[i+1] <= 1'b0;
			end else if (en) begin
				cd_vld_s[i+1] <= cd_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!cd_cy_s[i][CDC_W-1]) begin
					cd_cx_s[i+1]  <= cd_cx_s[i] + dx;
					cd_cy_s[i+1]  <= cd_cy_s[i] - dy;
					cd_acc_s[i+1] <= cd_acc_s[i] + ATAN_TAB[i];
				end else begin
					cd_cx_s[i+1]  <= cd_cx_s[i] - dx;
					cd_cy_s[i+1]  <= cd_cy_s[i] + dy;
					cd_acc_s[i+1] <= cd_acc_s[i] - ATAN_TAB[i];
				end
				cd_flg_s[i+1] <= cd_flg_s[i];
			end
		end
	end

	// clamp to [0, 90 deg] and round to the output scale
	logic signed [ACC_W-1:0] acc_last;
	logic [ACC_W-1:0]        acc_clamp;
	logic [ACC_W-1:0]        acc_rnd;

	assign acc_last  = cd_acc_s[CDC_STEPS];
	assign acc_clamp = acc_last[ACC_W-1] ? '0
		: (acc_last > ACC_TOP) ? $unsigned(ACC_TOP) : $unsigned(acc_last);
	assign acc_rnd   = (acc_clamp + RND_HALF) >> RND_SH;

	logic             vld_sr;
	logic [ACC_W-1:0] mag_sr;
	ata_flag_t        flg_sr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sr <= 1'b0;
		end else if (en) begin
			vld_sr <= cd_vld_s[CDC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_sr <= acc_rnd;
			flg_sr <= cd_flg_s[CDC_STEPS];
		end
	end

	// special cases, sign, saturation
	logic [ACC_W-1:0]      mag_sel;
	logic signed [ACC_W:0] ang;
	logic signed [ACC_W:0] ang_sat;

	assign mag_sel = flg_sr.rzero ? '0 : flg_sr.azero ? RIGHT_ANG : mag_sr;
	assign ang     = flg_sr.zneg ? -$signed({1'b0, mag_sel}) : $signed({1'b0, mag_sel});
	assign ang_sat = (ang > SAT_HI) ? SAT_HI : (ang < SAT_LO) ? SAT_LO : ang;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_sr;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tilt_angle    <= ang_sat[TILT_W-1:0];
			angle_invalid <= flg_sr.rzero && flg_sr.azero;
		end
	end

	a_stall_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item accepted while output stalled");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && angle_invalid |-> tilt_angle == '0)
		else $error("invalid item with nonzero angle");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(tilt_angle) <= ANG_LIM) && ($signed(tilt_angle) >= ANG_LO))
		else $error("tilt angle beyond 90 degrees");

endmodule
